// ----- hw/rtl/sgs_pkg.sv -----
`timescale 1ns / 1ps

package sgs_pkg;

    // Field and register widths
    localparam int BYTE_W    = 8;
    localparam int SRL_W     = 16;
    localparam int NRL_W     = 20;
    localparam int SAL_W     = 20;
    localparam int PAD_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int OUT_W     = 32;
    localparam int AREA_W    = 2;

    localparam int POS_WIDTH_DEF = 32;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    // Register reset values
    localparam logic [SRL_W-1:0] SRL_RST  = 16'd100;
    localparam logic [NRL_W-1:0] NRL_RST  = 20'd5120;
    localparam logic [SAL_W-1:0] SAL_RST  = 20'd40000;
    localparam logic [PAD_W-1:0] PAD_RST  = 12'd418;

    localparam logic [BYTE_W-1:0] SIL_LO = 8'h00;
    localparam logic [BYTE_W-1:0] SIL_HI = 8'hFF;

    localparam logic [OUT_W-1:0] CNT_MAX = '1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SILENCE_RUN_LEN  = 3'd0,
        REG_NOISE_RUN_LEN    = 3'd1,
        REG_SILENCE_AREA_LEN = 3'd2,
        REG_ONLY_TRIM        = 3'd3,
        REG_FRAME_PAD        = 3'd4
    } t_reg_idx;

    // Result kinds
    localparam logic KIND_MID = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             seg_valid;
        logic [OUT_W-1:0] seg_start;
        logic [OUT_W-1:0] seg_length;
        logic [OUT_W-1:0] seg_number;
        logic             silence_at_start;
        logic             silence_at_end;
        logic             is_last;
    } t_result;

endpackage

// ----- hw/rtl/silence_gap_segmenter.sv -----
`timescale 1ns / 1ps
// A byte request accepted on the input passes through the input register, the state
//   update register and the output queue before its results reach the output channel.
// Throughput: one byte per cycle while o_ready is high; a byte ending a segment and
//   the file gives two results, leaving the 8-entry output queue one per cycle
//   while i_ready is high. Reset (i_rst_n low, synchronous): registers return to
//   their defaults, all tracking state and the output queue are cleared.
module silence_gap_segmenter #(
    parameter int POS_WIDTH = sgs_pkg::POS_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [sgs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sgs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // byte channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sgs_pkg::BYTE_W-1:0]    i_byte_value,
    input  logic                          i_last_byte,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_kind,
    output logic                          o_seg_valid,
    output logic [sgs_pkg::OUT_W-1:0]     o_seg_start,
    output logic [sgs_pkg::OUT_W-1:0]     o_seg_length,
    output logic [sgs_pkg::OUT_W-1:0]     o_seg_number,
    output logic                          o_silence_at_start,
    output logic                          o_silence_at_end,
    output logic                          o_is_last
);
    import sgs_pkg::*;

    localparam int PW = POS_WIDTH;
    // compare width for distance vs. thresholds
    localparam int CW = (PW + 1 > NRL_W + 1) ? PW + 1 : NRL_W + 1;
    // signed width for padding math
    localparam int SW = PW + 3;
    localparam logic [PW-1:0] POS_MAX = '1;

    // raw segment as found by the tracking stage, before padding
    typedef struct packed {
        logic             kind;
        logic             seg_valid;
        logic [PW:0]      from;
        logic [PW-1:0]    to;
        logic [OUT_W-1:0] number;
        logic             sas;
        logic             sae;
        logic             is_last;
    } t_raw;

    // ---------------- configuration registers ----------------
    logic [SRL_W-1:0] r_srl;
    logic [NRL_W-1:0] r_nrl;
    logic [SAL_W-1:0] r_sal;
    logic             r_trim;
    logic [PAD_W-1:0] r_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srl  <= SRL_RST;
            r_nrl  <= NRL_RST;
            r_sal  <= SAL_RST;
            r_trim <= 1'b0;
            r_pad  <= PAD_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SILENCE_RUN_LEN:  r_srl  <= i_cfg_data[SRL_W-1:0];
                REG_NOISE_RUN_LEN:    r_nrl  <= i_cfg_data[NRL_W-1:0];
                REG_SILENCE_AREA_LEN: r_sal  <= i_cfg_data[SAL_W-1:0];
                REG_ONLY_TRIM:        r_trim <= i_cfg_data[0];
                REG_FRAME_PAD:        r_pad  <= i_cfg_data[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage A: input register ----------------
    logic              r_a_vld;
    logic [BYTE_W-1:0] r_a_byte;
    logic              r_a_last;
    logic              w_in_acc;

    assign w_in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_in_acc;
        end
        if (w_in_acc) begin
            r_a_byte <= i_byte_value;
            r_a_last <= i_last_byte;
        end
    end

    // ---------------- stage B: tracking state ----------------
    logic [PW-1:0]     r_pos,      n_pos;
    logic [OUT_W-1:0]  r_run,      n_run;
    logic              r_prev_vld, n_prev_vld;
    logic              r_prev_sil, n_prev_sil;
    logic              r_ils,      n_ils;      // in long silence
    logic [PW-1:0]     r_lsp,      n_lsp;      // latest long-silence byte
    logic              r_lss,      n_lss;
    logic              r_iln,      n_iln;      // in long noise
    logic [PW-1:0]     r_lnp,      n_lnp;      // latest long-noise byte
    logic              r_lns,      n_lns;
    logic [PW:0]       r_mark,     n_mark;     // pending segment start
    logic              r_mset,     n_mset;
    logic              r_isa,      n_isa;      // in silence area
    logic [AREA_W-1:0] r_areas,    n_areas;
    logic [OUT_W-1:0]  r_segs,     n_segs;
    logic              r_sflag,    n_sflag;

    logic              r_b_v0,  n_b_v0;        // mid-stream segment
    logic              r_b_v1,  n_b_v1;        // end-of-file report
    t_raw              r_b_r0,  n_b_r0;
    t_raw              r_b_r1,  n_b_r1;

    logic              w_sil;
    logic [CW-1:0]     w_d1, w_d2;
    logic [NRL_W-1:0]  w_thr;
    logic              w_noise, w_area;
    logic [PW-1:0]     w_area_st;

    always_comb begin
        n_pos      = r_pos;
        n_run      = r_run;
        n_prev_vld = r_prev_vld;
        n_prev_sil = r_prev_sil;
        n_ils      = r_ils;
        n_lsp      = r_lsp;
        n_lss      = r_lss;
        n_iln      = r_iln;
        n_lnp      = r_lnp;
        n_lns      = r_lns;
        n_mark     = r_mark;
        n_mset     = r_mset;
        n_isa      = r_isa;
        n_areas    = r_areas;
        n_segs     = r_segs;
        n_sflag    = r_sflag;
        n_b_v0     = 1'b0;
        n_b_v1     = 1'b0;
        n_b_r0     = r_b_r0;
        n_b_r1     = r_b_r1;

        w_sil     = (r_a_byte == SIL_LO) || (r_a_byte == SIL_HI);
        // distance+1 to the last long silence (old values: only used outside long silence)
        w_d1      = r_lss ? (CW'(r_pos) - CW'(r_lsp) + CW'(1)) : (CW'(r_pos) + CW'(2));
        // distance+1 to the last long noise (noise and area hits never share a byte)
        w_d2      = r_lns ? (CW'(r_pos) - CW'(r_lnp) + CW'(1)) : (CW'(r_pos) + CW'(2));
        w_thr     = r_trim ? NRL_W'(r_srl) : r_sal;
        w_area_st = r_lns ? r_lnp : '0;
        w_noise   = 1'b0;
        w_area    = 1'b0;

        if (r_a_vld) begin
            // silence run length
            if (r_prev_vld && r_prev_sil) begin
                if (r_run != CNT_MAX) n_run = r_run + OUT_W'(1);
            end else begin
                n_run = OUT_W'(1);
            end

            n_ils = w_sil && (n_run >= OUT_W'(r_srl));
            if (n_ils) begin
                n_lsp = r_pos;
                n_lss = 1'b1;
            end

            // long noise
            w_noise = !n_ils && (w_d1 >= CW'(r_nrl));
            if (w_noise) begin
                if (!r_iln && !r_mset) begin
                    n_mark = r_lss ? ({1'b0, r_lsp} + (PW+1)'(1)) : (PW+1)'(1);
                    n_mset = 1'b1;
                end
                n_lnp = r_pos;
                n_lns = 1'b1;
                n_iln = 1'b1;
                n_isa = 1'b0;
            end else begin
                n_iln = 1'b0;
            end

            // silence area
            w_area = n_ils && (w_d2 >= CW'(w_thr));
            if (w_area) begin
                if (!r_isa) begin
                    if (r_areas != AREA_W'(2)) n_areas = r_areas + AREA_W'(1);
                    if (r_mset && !r_trim) begin
                        if (r_segs != CNT_MAX) n_segs = r_segs + OUT_W'(1);
                        n_b_v0           = 1'b1;
                        n_b_r0.kind      = KIND_MID;
                        n_b_r0.seg_valid = 1'b1;
                        n_b_r0.from      = r_mark;
                        n_b_r0.to        = w_area_st;
                        n_b_r0.number    = n_segs;
                        n_b_r0.sas       = 1'b0;
                        n_b_r0.sae       = 1'b0;
                        n_b_r0.is_last   = !r_a_last;
                        n_mset           = 1'b0;
                        if (n_segs == OUT_W'(1) && n_areas > AREA_W'(1)) n_sflag = 1'b1;
                    end
                end
                n_isa = 1'b1;
            end

            n_prev_vld = 1'b1;
            n_prev_sil = w_sil;
            if (r_pos != POS_MAX) n_pos = r_pos + PW'(1);

            // end of file: flush and start over
            if (r_a_last) begin
                n_b_v1         = 1'b1;
                n_b_r1.kind    = KIND_END;
                n_b_r1.sas     = n_sflag;
                n_b_r1.is_last = 1'b1;
                if (n_mset) begin
                    if (n_segs != CNT_MAX) n_segs = n_segs + OUT_W'(1);
                    n_b_r1.seg_valid = 1'b1;
                    n_b_r1.from      = n_mark;
                    n_b_r1.to        = n_lnp;
                    n_b_r1.sae       = 1'b0;
                end else begin
                    n_b_r1.seg_valid = 1'b0;
                    n_b_r1.from      = '0;
                    n_b_r1.to        = '0;
                    n_b_r1.sae       = (n_segs != '0) && !n_iln;
                end
                n_b_r1.number = n_segs;

                n_pos      = '0;
                n_run      = '0;
                n_prev_vld = 1'b0;
                n_prev_sil = 1'b0;
                n_ils      = 1'b0;
                n_lsp      = '0;
                n_lss      = 1'b0;
                n_iln      = 1'b0;
                n_lnp      = '0;
                n_lns      = 1'b0;
                n_mark     = '0;
                n_mset     = 1'b0;
                n_isa      = 1'b0;
                n_areas    = '0;
                n_segs     = '0;
                n_sflag    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_run      <= '0;
            r_prev_vld <= 1'b0;
            r_prev_sil <= 1'b0;
            r_ils      <= 1'b0;
            r_lsp      <= '0;
            r_lss      <= 1'b0;
            r_iln      <= 1'b0;
            r_lnp      <= '0;
            r_lns      <= 1'b0;
            r_mark     <= '0;
            r_mset     <= 1'b0;
            r_isa      <= 1'b0;
            r_areas    <= '0;
            r_segs     <= '0;
            r_sflag    <= 1'b0;
            r_b_v0     <= 1'b0;
            r_b_v1     <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_run      <= n_run;
            r_prev_vld <= n_prev_vld;
            r_prev_sil <= n_prev_sil;
            r_ils      <= n_ils;
            r_lsp      <= n_lsp;
            r_lss      <= n_lss;
            r_iln      <= n_iln;
            r_lnp      <= n_lnp;
            r_lns      <= n_lns;
            r_mark     <= n_mark;
            r_mset     <= n_mset;
            r_isa      <= n_isa;
            r_areas    <= n_areas;
            r_segs     <= n_segs;
            r_sflag    <= n_sflag;
            r_b_v0     <= n_b_v0;
            r_b_v1     <= n_b_v1;
        end
        r_b_r0 <= n_b_r0;
        r_b_r1 <= n_b_r1;
    end

    // ---------------- stage C: padding, into the output queue ----------------
    function automatic logic [OUT_W-1:0] f_clip(input logic signed [SW-1:0] v);
        logic [SW-1:0] u;
        u = unsigned'(v);
        if (v[SW-1]) begin
            f_clip = '0;
        end else if ((u >> OUT_W) != '0) begin
            f_clip = CNT_MAX;
        end else begin
            f_clip = OUT_W'(u);
        end
    endfunction

    function automatic t_result f_pad(input t_raw r, input logic [PAD_W-1:0] pad);
        logic signed [SW-1:0] s_from;
        logic signed [SW-1:0] s_to;
        logic signed [SW-1:0] s_pad;
        logic signed [SW-1:0] s_raw;
        t_result o;
        s_from = signed'(SW'(r.from));
        s_to   = signed'(SW'(r.to));
        s_pad  = signed'(SW'(pad));
        s_raw  = s_to - s_from + SW'(1);
        if (s_raw[SW-1]) s_raw = '0;
        o.kind             = r.kind;
        o.seg_valid        = r.seg_valid;
        o.seg_start        = r.seg_valid ? f_clip(s_from - s_pad) : '0;
        o.seg_length       = r.seg_valid ? f_clip(s_raw + s_pad + s_pad) : '0;
        o.seg_number       = r.number;
        o.silence_at_start = r.sas;
        o.silence_at_end   = r.sae;
        o.is_last          = r.is_last;
        f_pad = o;
    endfunction

    t_result             r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp, r_rp;
    logic [FIFO_CW-1:0]  r_cnt;
    t_result             w_p0, w_p1;
    logic [1:0]          w_push;
    logic                w_pop;
    logic [FIFO_CW+1:0]  w_pend;

    assign w_p0   = f_pad(r_b_r0, r_pad);
    assign w_p1   = f_pad(r_b_r1, r_pad);
    assign w_push = {1'b0, r_b_v0} + {1'b0, r_b_v1};
    assign w_pop  = o_valid && i_ready;

    // every byte in flight may still need two slots
    assign w_pend  = (FIFO_CW+2)'(r_cnt) + (FIFO_CW+2)'({r_a_vld, 1'b0})
                   + (FIFO_CW+2)'({r_b_v0 | r_b_v1, 1'b0});
    assign o_ready = (w_pend + (FIFO_CW+2)'(2)) <= (FIFO_CW+2)'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FIFO_AW'(w_push);
            r_cnt <= r_cnt + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
            if (w_pop) r_rp <= r_rp + FIFO_AW'(1);
        end
        if (r_b_v0) begin
            r_fifo[r_wp] <= w_p0;
            if (r_b_v1) r_fifo[r_wp + FIFO_AW'(1)] <= w_p1;
        end else if (r_b_v1) begin
            r_fifo[r_wp] <= w_p1;
        end
    end

    assign o_valid            = (r_cnt != '0);
    assign o_kind             = r_fifo[r_rp].kind;
    assign o_seg_valid        = r_fifo[r_rp].seg_valid;
    assign o_seg_start        = r_fifo[r_rp].seg_start;
    assign o_seg_length       = r_fifo[r_rp].seg_length;
    assign o_seg_number       = r_fifo[r_rp].seg_number;
    assign o_silence_at_start = r_fifo[r_rp].silence_at_start;
    assign o_silence_at_end   = r_fifo[r_rp].silence_at_end;
    assign o_is_last          = r_fifo[r_rp].is_last;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sgs_pkg::*;

    localparam int     DRAIN_CYCLES = 4;      // covers stages A and B, plus margin
    localparam int     END_SETTLE   = 8;
    localparam int     MAX_REPORTS  = 200;    // keep the log short on a badly broken build
    localparam int     FILL_STOP    = 1500;   // no new phase once this many bytes are queued
    localparam int     FILL_CAP     = 1530;   // a phase stops filling here
    localparam longint LIMIT_NS     = 64'd12 * 64'd200_000;
    localparam bit [63:0] POS_MAX   = (64'd1 << POS_WIDTH_DEF) - 64'd1;
    localparam bit [63:0] SAT_32    = 64'hFFFF_FFFF;

    // Work list for the byte driver: bytes, register writes and sync points.
    // A sync point holds the sender until every predicted result has drained.
    typedef enum logic [1:0] {FEED_BYTE, FEED_CFG, FEED_SYNC} t_feed_op;

    typedef struct packed {
        t_feed_op             op;
        logic [BYTE_W-1:0]    value;
        logic                 is_end;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
    } t_feed;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data   = '0;
    logic                 i_valid      = 1'b0;
    logic                 o_ready;
    logic [BYTE_W-1:0]    i_byte_value = '0;
    logic                 i_last_byte  = 1'b0;
    logic                 o_valid;
    logic                 i_ready      = 1'b0;
    logic                 o_kind;
    logic                 o_seg_valid;
    logic [OUT_W-1:0]     o_seg_start;
    logic [OUT_W-1:0]     o_seg_length;
    logic [OUT_W-1:0]     o_seg_number;
    logic                 o_silence_at_start;
    logic                 o_silence_at_end;
    logic                 o_is_last;

    silence_gap_segmenter u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_byte_value       (i_byte_value),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_seg_valid        (o_seg_valid),
        .o_seg_start        (o_seg_start),
        .o_seg_length       (o_seg_length),
        .o_seg_number       (o_seg_number),
        .o_silence_at_start (o_silence_at_start),
        .o_silence_at_end   (o_silence_at_end),
        .o_is_last          (o_is_last)
    );

    t_feed   byte_feed_q[$];
    t_result expected_segments[$];

    int fed_bytes    = 0;   // bytes queued by the stimulus
    int bytes_taken  = 0;   // byte requests accepted by the block
    int results_seen = 0;
    int fail_count   = 0;
    int quiet_cycles = 0;

    // Thresholds the stimulus shapes its runs around (set when queued)
    int plan_sil   = 100;
    int plan_noise = 5120;
    int plan_area  = 40000;

    // No random idling on either side for a stretch in the middle of the run
    wire calm = (bytes_taken >= 700) && (bytes_taken < 1000);

    // ------------------------------------------------------------------
    // Segment predictor: register copies and tracking state
    // ------------------------------------------------------------------
    logic [SRL_W-1:0] cf_sil_run   = SRL_RST;
    logic [NRL_W-1:0] cf_noise_run = NRL_RST;
    logic [SAL_W-1:0] cf_area      = SAL_RST;
    logic             cf_trim      = 1'b0;
    logic [PAD_W-1:0] cf_pad       = PAD_RST;

    bit [63:0] pos_now    = '0;   // position of the next byte, saturating
    bit [63:0] run_now    = '0;   // length of the current silence-byte run
    bit [63:0] sil_pos    = '0;   // latest byte of a long silence run
    bit [63:0] noise_pos  = '0;   // latest byte of a long noise run
    bit [63:0] marker_pos = '0;   // start of the pending segment
    bit [63:0] seg_total  = '0;
    bit [1:0]  area_total = '0;   // silence areas seen, stops at two
    bit have_prev = 0, prev_sil = 0, in_sil = 0, sil_seen = 0;
    bit in_noise = 0, noise_seen = 0, marker_on = 0, in_area = 0, lead_silence = 0;

    function automatic logic [OUT_W-1:0] clip_u32(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(SAT_32))
            return '1;
        return v[OUT_W-1:0];
    endfunction

    // Padded segment [from, to]; seg_number is the running total at the time
    function automatic t_result segment_result(input logic kind, input logic valid,
                                               input bit [63:0] from, input bit [63:0] to,
                                               input logic sas, input logic sae);
        t_result r;
        longint  span;
        r = '0;
        r.kind      = kind;
        r.seg_valid = valid;
        if (valid) begin
            span = longint'(to) - longint'(from) + 1;
            if (span < 0)
                span = 0;
            r.seg_start  = clip_u32(longint'(from) - longint'(cf_pad));
            r.seg_length = clip_u32(span + 2 * longint'(cf_pad));
        end
        r.seg_number       = seg_total[OUT_W-1:0];
        r.silence_at_start = sas;
        r.silence_at_end   = sae;
        return r;
    endfunction

    task automatic predict_segments(input logic [BYTE_W-1:0] b, input logic is_end);
        t_result   res [2];
        int        n;
        bit [63:0] p;
        bit [63:0] gap;
        bit [63:0] thr;
        bit [63:0] origin;
        bit        silent;
        n      = 0;
        p      = pos_now;
        silent = (b == SIL_LO) || (b == SIL_HI);

        if (have_prev && prev_sil) begin
            if (run_now < SAT_32)
                run_now++;
        end else begin
            run_now = 1;
        end

        if (silent && run_now >= cf_sil_run) begin
            sil_pos  = p;
            sil_seen = 1;
            in_sil   = 1;
        end else begin
            in_sil = 0;
        end

        // Long noise: far enough from the last long silence (from -1 if none yet)
        gap = sil_seen ? (p - sil_pos) : (p + 1);
        if (!in_sil && gap + 1 >= cf_noise_run) begin
            if (!in_noise && !marker_on) begin
                marker_pos = (sil_seen ? sil_pos : 64'd0) + 1;
                marker_on  = 1;
            end
            noise_pos  = p;
            noise_seen = 1;
            in_noise   = 1;
            in_area    = 0;
        end else begin
            in_noise = 0;
        end

        // Silence area: trim mode uses the short run threshold
        thr = cf_trim ? 64'(cf_sil_run) : 64'(cf_area);
        gap = noise_seen ? (p - noise_pos) : (p + 1);
        if (in_sil && gap + 1 >= thr) begin
            if (!in_area) begin
                origin = noise_seen ? noise_pos : 64'd0;
                if (area_total < 2)
                    area_total++;
                if (marker_on && !cf_trim) begin
                    if (seg_total < SAT_32)
                        seg_total++;
                    res[n] = segment_result(KIND_MID, 1'b1, marker_pos, origin, 1'b0, 1'b0);
                    n++;
                    marker_on = 0;
                    if (seg_total == 1 && area_total > 1)
                        lead_silence = 1;
                end
            end
            in_area = 1;
        end

        have_prev = 1;
        prev_sil  = silent;
        if (pos_now < POS_MAX)
            pos_now++;

        if (is_end) begin
            if (marker_on) begin
                if (seg_total < SAT_32)
                    seg_total++;
                res[n] = segment_result(KIND_END, 1'b1, marker_pos, noise_pos,
                                        lead_silence, 1'b0);
            end else begin
                res[n] = segment_result(KIND_END, 1'b0, 64'd0, 64'd0, lead_silence,
                                        (seg_total > 0) && !in_noise);
            end
            n++;
            // new file: tracking starts over, registers stay
            pos_now = '0; run_now = '0; sil_pos = '0; noise_pos = '0; marker_pos = '0;
            seg_total = '0; area_total = '0;
            have_prev = 0; prev_sil = 0; in_sil = 0; sil_seen = 0; in_noise = 0;
            noise_seen = 0; marker_on = 0; in_area = 0; lead_silence = 0;
        end

        if (n > 0)
            res[n-1].is_last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_segments.push_back(res[k]);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] value, input logic is_end);
        byte_feed_q.push_back({FEED_BYTE, value, is_end, {CFG_IDX_W{1'b0}},
                               {CFG_DAT_W{1'b0}}});
        fed_bytes++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        byte_feed_q.push_back({FEED_CFG, {BYTE_W{1'b0}}, 1'b0, idx, data});
    endtask

    task automatic push_sync();
        byte_feed_q.push_back({FEED_SYNC, {BYTE_W{1'b0}}, 1'b0, {CFG_IDX_W{1'b0}},
                               {CFG_DAT_W{1'b0}}});
    endtask

    // A run of silence bytes (mixed 0x00 / 0xFF) or noise bytes; can close the file
    task automatic push_run(input int len, input bit silent, input bit closes);
        for (int k = 0; k < len; k++)
            push_byte(silent ? ($urandom_range(1) ? SIL_HI : SIL_LO)
                             : 8'($urandom_range(1, 254)),
                      closes && (k == len - 1));
    endtask

    // Alternating silence and noise runs sized around the current thresholds
    task automatic push_file(input bit closes);
        int runs;
        int lim;
        bit silent;
        runs   = $urandom_range(1, 8);
        silent = 1'($urandom_range(1));
        for (int r = 0; r < runs; r++) begin
            lim = silent ? ((plan_sil > plan_area) ? plan_sil : plan_area) : plan_noise;
            if (lim > 36)
                lim = 36;
            push_run($urandom_range(1, lim + 4), silent, closes && (r == runs - 1));
            silent = !silent;
        end
    endtask

    // Register writes go out only once the block has drained; spare data bits random
    task automatic set_config(input logic [SRL_W-1:0] sil, input logic [NRL_W-1:0] noise,
                              input logic [SAL_W-1:0] area, input logic trim,
                              input logic [PAD_W-1:0] pad);
        logic [CFG_DAT_W-1:0] d;
        push_sync();
        d = CFG_DAT_W'($urandom);
        d[SRL_W-1:0] = sil;
        push_cfg(REG_SILENCE_RUN_LEN, d);
        push_cfg(REG_NOISE_RUN_LEN, noise);
        push_cfg(REG_SILENCE_AREA_LEN, area);
        d = CFG_DAT_W'($urandom);
        d[0] = trim;
        push_cfg(REG_ONLY_TRIM, d);
        d = CFG_DAT_W'($urandom);
        d[PAD_W-1:0] = pad;
        push_cfg(REG_FRAME_PAD, d);
        // an index past the register map must change nothing
        push_cfg(CFG_IDX_W'($urandom_range(int'(REG_FRAME_PAD) + 1, (1 << CFG_IDX_W) - 1)),
                 CFG_DAT_W'($urandom));
        plan_sil   = int'(sil);
        plan_noise = int'(noise);
        plan_area  = int'(area);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, time limit
    // ------------------------------------------------------------------
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(LIMIT_NS);
        $display("[silence_gap_segmenter] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Byte driver: works down the feed list. Each output gets exactly one
    // nonblocking write per edge, so a held request is never dropped and
    // re-raised in the same step.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic                 v_nxt;
        logic [BYTE_W-1:0]    b_nxt;
        logic                 l_nxt;
        logic                 we_nxt;
        logic [CFG_IDX_W-1:0] idx_nxt;
        logic [CFG_DAT_W-1:0] dat_nxt;
        t_feed                head;
        v_nxt   = i_valid;
        b_nxt   = i_byte_value;
        l_nxt   = i_last_byte;
        we_nxt  = 1'b0;
        idx_nxt = i_cfg_idx;
        dat_nxt = i_cfg_data;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_segments(i_byte_value, i_last_byte);
                bytes_taken++;
                v_nxt = 1'b0;
            end
            if (!v_nxt && byte_feed_q.size() > 0) begin
                head = byte_feed_q[0];
                case (head.op)
                    FEED_BYTE: begin
                        if (calm || $urandom_range(99) >= 21) begin
                            v_nxt = 1'b1;
                            b_nxt = head.value;
                            l_nxt = head.is_end;
                            void'(byte_feed_q.pop_front());
                        end
                    end
                    FEED_CFG: begin
                        we_nxt  = 1'b1;
                        idx_nxt = head.idx;
                        dat_nxt = head.data;
                        case (head.idx)
                            REG_SILENCE_RUN_LEN:  cf_sil_run   = head.data[SRL_W-1:0];
                            REG_NOISE_RUN_LEN:    cf_noise_run = head.data[NRL_W-1:0];
                            REG_SILENCE_AREA_LEN: cf_area      = head.data[SAL_W-1:0];
                            REG_ONLY_TRIM:        cf_trim      = head.data[0];
                            REG_FRAME_PAD:        cf_pad       = head.data[PAD_W-1:0];
                            default: ;
                        endcase
                        void'(byte_feed_q.pop_front());
                    end
                    default: begin
                        // sync point: all results in, then a quiet wait so that a
                        // byte that gave none can clear the pipeline
                        if (expected_segments.size() != 0) begin
                            quiet_cycles = 0;
                        end else if (quiet_cycles >= DRAIN_CYCLES) begin
                            quiet_cycles = 0;
                            void'(byte_feed_q.pop_front());
                        end else begin
                            quiet_cycles++;
                        end
                    end
                endcase
            end
        end
        i_valid      <= v_nxt;
        i_byte_value <= b_nxt;
        i_last_byte  <= l_nxt;
        i_cfg_we     <= we_nxt;
        i_cfg_idx    <= idx_nxt;
        i_cfg_data   <= dat_nxt;
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_kind, o_seg_valid, o_seg_start, o_seg_length, o_seg_number,
                       o_silence_at_start, o_silence_at_end, o_is_last};
                results_seen++;
                if (expected_segments.size() == 0) begin
                    report_mismatch("result arrived with none expected");
                end else begin
                    want = expected_segments.pop_front();
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("seg_valid", 32'(got.seg_valid), 32'(want.seg_valid));
                    check_field("seg_start", got.seg_start, want.seg_start);
                    check_field("seg_length", got.seg_length, want.seg_length);
                    check_field("seg_number", got.seg_number, want.seg_number);
                    check_field("silence_at_start", 32'(got.silence_at_start),
                                32'(want.silence_at_start));
                    check_field("silence_at_end", 32'(got.silence_at_end),
                                32'(want.silence_at_end));
                    check_field("is_last", 32'(got.is_last), 32'(want.is_last));
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        int               phase;
        int               phase_end;
        int               len;
        logic [SRL_W-1:0] s;
        logic [NRL_W-1:0] nr;
        logic [SAL_W-1:0] ar;
        logic             tr;
        logic [PAD_W-1:0] pd;

        // Directed: one-byte file under reset defaults, no segment
        push_byte(SIL_LO, 1'b1);

        // Short thresholds. Leading silence area before any long noise (area
        // from 0), then long noise (segment from 2) that a later silence run does
        // not close, then a flush of the open segment.
        set_config(2, 3, 3, 1'b0, 2);
        push_run(2, 1'b1, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_run(2, 1'b1, 1'b0);
        push_run(3, 1'b0, 1'b1);
        // A silence run ends the file too soon after the long noise to open an area:
        // the open segment comes out in the end report
        push_run(4, 1'b0, 1'b0);
        push_run(2, 1'b1, 1'b1);
        // Trim mode: an area is found but only the final segment comes out
        set_config(2, 3, 3, 1'b1, 0);
        push_run(4, 1'b0, 1'b0);
        push_run(2, 1'b1, 1'b0);
        push_run(3, 1'b0, 1'b1);

        // Random phases; the first two pin every register but the trim flag to its extremes
        phase = 0;
        while (fed_bytes < FILL_STOP) begin
            phase++;
            if (phase == 1) begin
                set_config('0, '0, '0, 1'($urandom_range(1)), '0);
            end else if (phase == 2) begin
                set_config('1, '1, '1, 1'($urandom_range(1)), '1);
            end else begin
                s = SRL_W'($urandom_range(1, 6));
                if ($urandom_range(9) == 0)
                    s = SRL_W'($urandom);
                nr = NRL_W'($urandom_range(1, 16));
                if ($urandom_range(9) == 0)
                    nr = NRL_W'($urandom);
                ar = SAL_W'($urandom_range(1, 24));
                if ($urandom_range(9) == 0)
                    ar = SAL_W'($urandom);
                tr = ($urandom_range(3) == 0);
                pd = PAD_W'($urandom_range(0, 24));
                case ($urandom_range(5))
                    0: pd = '0;
                    1: pd = '1;
                    2: pd = PAD_W'($urandom);
                    default: ;
                endcase
                set_config(s, nr, ar, tr, pd);
            end
            phase_end = fed_bytes + $urandom_range(60, 160);
            while (fed_bytes < phase_end && fed_bytes < FILL_CAP) begin
                case ($urandom_range(19))
                    0, 1, 2: begin
                        // unstructured bytes of any value
                        len = $urandom_range(1, 12);
                        for (int k = 0; k < len; k++)
                            push_byte(BYTE_W'($urandom), k == len - 1);
                    end
                    3, 4: push_file(1'b0);   // runs that carry into the next file
                    5:    push_sync();       // hold the sender until all results are in
                    default: push_file(1'b1);
                endcase
            end
        end
        push_sync();

        while (byte_feed_q.size() != 0)
            @(posedge i_clk);
        repeat (END_SETTLE) @(posedge i_clk);
        if (expected_segments.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_segments.size()));

        if (fail_count == 0)
            $display("[silence_gap_segmenter] OK");
        else
            $display("[silence_gap_segmenter] ERROR");
        $finish;
    end

endmodule
